@@ rtl/sorted_key_table_top_macros.svh @@
// Assertion helpers for the sorted key table.
`ifndef SORTED_KEY_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SKT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/skt_pkg.sv @@
package skt_pkg;

    localparam int SKT_DEPTH = 256;
    localparam int KEY_W     = 32;
    localparam int POS_W     = 8;
    localparam int CNT_W     = 9;
    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_DEL_AT  = 2'd2,
        CMD_DEL_VAL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] position;
    } skt_in_t;

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] value;
        logic [CNT_W-1:0] count;
    } skt_out_t;

    typedef struct packed {
        logic             ins;
        logic             del_at;
        logic             del_val;
        logic [KEY_W-1:0] key;
    } skt_cell_ctrl_t;

    typedef struct packed {
        logic le;
        logic ge;
        logic eq;
    } skt_cell_flag_t;

endpackage

@@ rtl/sorted_key_table_top.sv @@
// Sorted key table: holds up to min(capacity, DEPTH) unsigned 32-bit keys in ascending
// order in a row of DEPTH cells, one key per cell. Every command (insert, lookup by index,
// remove at index, remove by value) acts on all cells at once: each cell compares its key with
// the command key and its index with the position, then loads its own key, the command key,
// or a neighbor's key. A new transaction is taken every cycle while the result register is
// free or being drained, so the sustained rate is one transaction per cycle. The single
// result per transaction carries status, the looked-up key (zero otherwise) and the count
// after the command. Capacity may be written only while the block is idle; no clearing pass.
module sorted_key_table_top #(
    parameter int DEPTH = skt_pkg::SKT_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [skt_pkg::CNT_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  skt_pkg::skt_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output skt_pkg::skt_out_t             m_data
);
    import skt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int LW = (CW > CNT_W) ? CW : CNT_W;

    logic [CNT_W-1:0] cap_reg;
    logic [CW-1:0]    held_reg;
    logic [CW-1:0]    held_next;
    logic             m_valid_reg;
    skt_out_t         out_reg;
    skt_out_t         out_next;

    logic             fire;
    logic [PW-1:0]    pos_w;
    logic             room;
    logic             pos_ok;
    logic             found;
    logic [KEY_W-1:0] rd_any;
    skt_cell_ctrl_t   ctrl;

    logic [KEY_W-1:0] cell_key [DEPTH];
    logic [KEY_W-1:0] cell_rd  [DEPTH];
    skt_cell_flag_t   cell_flag [DEPTH];
    logic [DEPTH-1:0] eq_vec;

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign pos_w  = PW'(s_data.position);
    assign pos_ok = pos_w < PW'(held_reg);
    assign room   = (LW'(held_reg) < LW'(cap_reg)) && (held_reg < CW'(DEPTH));
    assign found  = |eq_vec;

    always_comb begin
        rd_any = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    assign ctrl.key     = s_data.key;
    assign ctrl.ins     = fire && (s_data.cmd == CMD_INSERT) && room;
    assign ctrl.del_at  = fire && (s_data.cmd == CMD_DEL_AT) && pos_ok;
    assign ctrl.del_val = fire && (s_data.cmd == CMD_DEL_VAL) && found;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic             left_le;
        logic [KEY_W-1:0] left_key;
        logic [KEY_W-1:0] right_key;

        if (g == 0) begin : g_first
            assign left_le  = 1'b1;
            assign left_key = '0;
        end else begin : g_mid
            assign left_le  = cell_flag[g-1].le;
            assign left_key = cell_key[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_key = '0;
        end else begin : g_inner
            assign right_key = cell_key[g+1];
        end

        assign eq_vec[g] = cell_flag[g].eq;

        skt_cell #(
            .INDEX(g),
            .CW   (CW),
            .PW   (PW)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .held     (held_reg),
            .pos      (pos_w),
            .left_le  (left_le),
            .left_key (left_key),
            .right_key(right_key),
            .key_out  (cell_key[g]),
            .flag     (cell_flag[g]),
            .rd_data  (cell_rd[g])
        );
    end

    always_comb begin
        held_next = held_reg;
        if (ctrl.ins) begin
            held_next = held_reg + CW'(1);
        end else if (ctrl.del_at || ctrl.del_val) begin
            held_next = held_reg - CW'(1);
        end
    end

    always_comb begin
        out_next.status = ST_OK;
        out_next.value  = '0;
        unique case (s_data.cmd)
            CMD_INSERT: begin
                if (!room) out_next.status = ST_FULL;
            end
            CMD_LOOKUP: begin
                if (!pos_ok) out_next.status = ST_RANGE;
                else         out_next.value  = rd_any;
            end
            CMD_DEL_AT: begin
                if (!pos_ok) out_next.status = ST_RANGE;
            end
            CMD_DEL_VAL: begin
                if (!found) out_next.status = ST_NOTFOUND;
            end
            default: out_next.status = ST_OK;
        endcase
        out_next.count = CNT_W'(held_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            held_reg <= held_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

`include "sorted_key_table_top_macros.svh"

    `SKT_ASSERT_IMPL(a_held_bound, 1'b1, held_reg <= CW'(DEPTH), "held count exceeds depth")
    `SKT_ASSERT_NEXT(a_result_count, fire, m_valid && (m_data.count == CNT_W'(held_reg)), "result count mismatch")
    `SKT_ASSERT_NEXT(a_insert_grows, ctrl.ins, held_reg == $past(held_reg) + CW'(1), "insert did not grow table")
    `SKT_ASSERT_IMPL(a_one_update, 1'b1, $onehot0({ctrl.ins, ctrl.del_at, ctrl.del_val}), "conflicting cell updates")

endmodule

@@ rtl/skt_cell.sv @@
module skt_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 9,
    parameter int PW    = 9
) (
    input  logic                         aclk,
    input  skt_pkg::skt_cell_ctrl_t      ctrl,
    input  logic [CW-1:0]                held,
    input  logic [PW-1:0]                pos,
    input  logic                         left_le,
    input  logic [skt_pkg::KEY_W-1:0]    left_key,
    input  logic [skt_pkg::KEY_W-1:0]    right_key,
    output logic [skt_pkg::KEY_W-1:0]    key_out,
    output skt_pkg::skt_cell_flag_t      flag,
    output logic [skt_pkg::KEY_W-1:0]    rd_data
);
    import skt_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             live;
    logic             at_pos;

    assign live   = CW'(INDEX) < held;
    assign at_pos = PW'(INDEX) >= pos;

    assign flag.le = live && (key_reg <= ctrl.key);
    assign flag.ge = live && (key_reg >= ctrl.key);
    assign flag.eq = live && (key_reg == ctrl.key);

    assign key_out = key_reg;
    assign rd_data = (PW'(INDEX) == pos) ? key_reg : '0;

    always_comb begin
        key_next = key_reg;
        if (ctrl.ins && !flag.le) begin
            key_next = left_le ? ctrl.key : left_key;
        end else if ((ctrl.del_at && at_pos) || (ctrl.del_val && flag.ge)) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule
